// File: rtl/core/sacs_pkg.sv
// Shared constants and types for the speed alarm chime sequencer.
`default_nettype none

package sacs_pkg;

  localparam int CLOCK_HZ_DEFAULT = 16000000;
  localparam int PRESCALE         = 8;

  localparam int F_HIGH_HZ = 2000;
  localparam int F_MID_HZ  = 1000;
  localparam int F_LOW_HZ  = 500;

  localparam int LEN_RISE_MS = 450;
  localparam int LEN_FALL_MS = 250;

  localparam int PERIOD_W = 12;
  localparam int TOGGLE_W = 11;
  localparam int PERIOD_MAX = (1 << PERIOD_W) - 1;

  // Frequency codes, lowest pitch first.
  localparam logic [1:0] FREQ_LOW  = 2'd0;
  localparam logic [1:0] FREQ_MID  = 2'd1;
  localparam logic [1:0] FREQ_HIGH = 2'd2;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  localparam logic [1:0] LAST_STEP = 2'd2;

  // Toggle budgets, 2 * freq * length / 1000, for each chime direction.
  localparam logic [TOGGLE_W-1:0] TOG_RISE_LOW  = TOGGLE_W'(2 * F_LOW_HZ  * LEN_RISE_MS / 1000);
  localparam logic [TOGGLE_W-1:0] TOG_RISE_MID  = TOGGLE_W'(2 * F_MID_HZ  * LEN_RISE_MS / 1000);
  localparam logic [TOGGLE_W-1:0] TOG_RISE_HIGH = TOGGLE_W'(2 * F_HIGH_HZ * LEN_RISE_MS / 1000);
  localparam logic [TOGGLE_W-1:0] TOG_FALL_LOW  = TOGGLE_W'(2 * F_LOW_HZ  * LEN_FALL_MS / 1000);
  localparam logic [TOGGLE_W-1:0] TOG_FALL_MID  = TOGGLE_W'(2 * F_MID_HZ  * LEN_FALL_MS / 1000);
  localparam logic [TOGGLE_W-1:0] TOG_FALL_HIGH = TOGGLE_W'(2 * F_HIGH_HZ * LEN_FALL_MS / 1000);

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [TOGGLE_W-1:0] toggles;
  } tone_t;

endpackage

`default_nettype wire

// File: rtl/core/sacs_tone_sel.sv
// Tone lookup: divider period and toggle budget for a chime step and direction.
`default_nettype none

module sacs_tone_sel #(
  parameter int CLOCK_HZ = sacs_pkg::CLOCK_HZ_DEFAULT
) (
  input  wire logic [1:0]      step,
  input  wire logic            descending,
  output sacs_pkg::tone_t      tone
);

  localparam int PW = sacs_pkg::PERIOD_W;

  localparam int RAW_LOW  = CLOCK_HZ / (2 * sacs_pkg::PRESCALE * sacs_pkg::F_LOW_HZ);
  localparam int RAW_MID  = CLOCK_HZ / (2 * sacs_pkg::PRESCALE * sacs_pkg::F_MID_HZ);
  localparam int RAW_HIGH = CLOCK_HZ / (2 * sacs_pkg::PRESCALE * sacs_pkg::F_HIGH_HZ);

  localparam int PER_LOW  = (RAW_LOW < 1) ? 1 :
                            ((RAW_LOW > sacs_pkg::PERIOD_MAX) ? sacs_pkg::PERIOD_MAX : RAW_LOW);
  localparam int PER_MID  = (RAW_MID < 1) ? 1 :
                            ((RAW_MID > sacs_pkg::PERIOD_MAX) ? sacs_pkg::PERIOD_MAX : RAW_MID);
  localparam int PER_HIGH = (RAW_HIGH < 1) ? 1 :
                            ((RAW_HIGH > sacs_pkg::PERIOD_MAX) ? sacs_pkg::PERIOD_MAX : RAW_HIGH);

  logic [1:0] idx;
  logic [1:0] freq;

  // A step beyond the last is played as the last tone.
  assign idx  = (step > sacs_pkg::LAST_STEP) ? sacs_pkg::LAST_STEP : step;
  assign freq = descending ? (sacs_pkg::LAST_STEP - idx) : idx;

  always_comb begin
    unique case (freq)
      sacs_pkg::FREQ_LOW: begin
        tone.period  = PW'(PER_LOW);
        tone.toggles = descending ? sacs_pkg::TOG_FALL_LOW : sacs_pkg::TOG_RISE_LOW;
      end
      sacs_pkg::FREQ_MID: begin
        tone.period  = PW'(PER_MID);
        tone.toggles = descending ? sacs_pkg::TOG_FALL_MID : sacs_pkg::TOG_RISE_MID;
      end
      default: begin
        tone.period  = PW'(PER_HIGH);
        tone.toggles = descending ? sacs_pkg::TOG_FALL_HIGH : sacs_pkg::TOG_RISE_HIGH;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/speed_alarm_chime_sequencer.sv
// Top level of the speed alarm chime sequencer.
//
//   channel | direction | payload
//   --------+-----------+---------------------------------------------------
//   in_     | slave     | tdata[11:0] speed, tuser action (0 tick, 1 start)
//   out_    | master    | tdata[0] buzzer_level, [1] busy_res, [2] start_ignored
//   cfg_    | slave     | data[7:0] speed_threshold (signed)
//
// Each item is processed in the cycle it is accepted and its result appears in
// the output register on the next cycle; one item per cycle is sustained while out_tready is high.
// The output register is the only stage, so in_tready follows out_tready
// whenever a result is held. cfg_ready is always high.
// rst_n is synchronous and active low; it clears the chime state and threshold.
`default_nettype none

module speed_alarm_chime_sequencer #(
  parameter int CLOCK_HZ = sacs_pkg::CLOCK_HZ_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] speed, [15:12] zero
  input  wire logic        in_tuser,   // [0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [0] buzzer_level, [1] busy_res,
                                       // [2] start_ignored, [7:3] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  localparam int PW = sacs_pkg::PERIOD_W;
  localparam int TW = sacs_pkg::TOGGLE_W;

  logic signed [7:0] thresh_r;
  logic [1:0]        step_r, step_nxt;
  logic              desc_r, desc_nxt;
  logic [PW-1:0]     div_r, div_nxt;
  logic [TW-1:0]     tog_r, tog_nxt;
  logic              pin_r, pin_nxt;
  logic              play_r, play_nxt;
  logic              out_valid_r;
  logic [7:0]        out_data_r;

  logic              in_acc;
  logic              ignored;
  logic [11:0]       speed;
  logic signed [12:0] speed_s;
  logic signed [12:0] limit_s;
  logic              start_desc;
  logic [1:0]        load_step;
  logic              load_desc;
  logic [PW:0]       div_inc;
  sacs_pkg::tone_t   cur_tone;
  sacs_pkg::tone_t   load_tone;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign speed   = in_tdata[11:0];
  assign speed_s = $signed({1'b0, speed});
  // threshold * 10 as (t << 3) + (t << 1)
  assign limit_s = ($signed({{5{thresh_r[7]}}, thresh_r}) <<< 3)
                 + ($signed({{5{thresh_r[7]}}, thresh_r}) <<< 1);
  assign start_desc = !(speed_s <= limit_s);

  // The tone being loaded: the first of a new chime, or the next in this one.
  assign load_step = (in_tuser == sacs_pkg::ACT_START) ? 2'd0 : (step_r + 2'd1);
  assign load_desc = (in_tuser == sacs_pkg::ACT_START) ? start_desc : desc_r;

  sacs_tone_sel #(.CLOCK_HZ(CLOCK_HZ)) u_cur_tone (
    .step       (step_r),
    .descending (desc_r),
    .tone       (cur_tone)
  );

  sacs_tone_sel #(.CLOCK_HZ(CLOCK_HZ)) u_load_tone (
    .step       (load_step),
    .descending (load_desc),
    .tone       (load_tone)
  );

  assign div_inc = {1'b0, div_r} + {{PW{1'b0}}, 1'b1};

  always_comb begin
    step_nxt = step_r;
    desc_nxt = desc_r;
    div_nxt  = div_r;
    tog_nxt  = tog_r;
    pin_nxt  = pin_r;
    play_nxt = play_r;
    ignored  = 1'b0;
    if (in_tuser == sacs_pkg::ACT_START) begin
      if (play_r) begin
        ignored = 1'b1;
      end else begin
        desc_nxt = start_desc;
        step_nxt = 2'd0;
        play_nxt = 1'b1;
        tog_nxt  = load_tone.toggles;
        div_nxt  = '0;
      end
    end else if (play_r) begin
      if (div_inc >= {1'b0, cur_tone.period}) begin
        div_nxt = '0;
        if (tog_r == '0) begin
          // An exhausted tone ends on this match; the next tone starts at once, or the chime stops after the last.
          if (step_r >= sacs_pkg::LAST_STEP) begin
            play_nxt = 1'b0;
            step_nxt = 2'd0;
          end else begin
            step_nxt = step_r + 2'd1;
            tog_nxt  = load_tone.toggles;
          end
        end else begin
          pin_nxt = !pin_r;
          tog_nxt = tog_r - {{(TW-1){1'b0}}, 1'b1};
        end
      end else begin
        div_nxt = div_inc[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= '0;
      step_r      <= '0;
      desc_r      <= 1'b0;
      div_r       <= '0;
      tog_r       <= '0;
      pin_r       <= 1'b0;
      play_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thresh_r <= $signed(cfg_data);
      end
      if (in_acc) begin
        step_r      <= step_nxt;
        desc_r      <= desc_nxt;
        div_r       <= div_nxt;
        tog_r       <= tog_nxt;
        pin_r       <= pin_nxt;
        play_r      <= play_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {5'b0, ignored, play_nxt, pin_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
